>>> design/bcd_pkg.sv
// shared constants and endpoint expansion tables for the bc1/bc3 block decoder
package bcd_pkg;

	// largest image side honored by the clipping logic
	localparam logic [13:0] MAX_SIDE = 14'd8192;

	// configuration register indexes
	localparam logic [1:0] CFG_FORMAT = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	localparam logic [13:0] RST_WIDTH  = 14'd256;
	localparam logic [13:0] RST_HEIGHT = 14'd256;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

	// truncating x*255/31, one byte per entry
	function automatic logic [255:0] exp5_tab();
		logic [255:0] tab;
		tab = '0;
		for (int i = 0; i < 32; i++) begin
			tab[i*8 +: 8] = 8'(i * 255 / 31);
		end
		return tab;
	endfunction

	// truncating x*255/63, one byte per entry
	function automatic logic [511:0] exp6_tab();
		logic [511:0] tab;
		tab = '0;
		for (int i = 0; i < 64; i++) begin
			tab[i*8 +: 8] = 8'(i * 255 / 63);
		end
		return tab;
	endfunction

	localparam logic [255:0] EXP5_TAB = exp5_tab();
	localparam logic [511:0] EXP6_TAB = exp6_tab();

	// rgb565 to rgb888, red in 23..16, blue in 7..0
	function automatic logic [23:0] expand565(input logic [15:0] c);
		return {EXP5_TAB[{c[15:11], 3'b000} +: 8],
			EXP6_TAB[{c[10:5], 3'b000} +: 8],
			EXP5_TAB[{c[4:0], 3'b000} +: 8]};
	endfunction

endpackage

>>> design/bcd_ifs.sv
// valid/ready channels for compressed blocks in and decoded texels out
interface bcd_blk_if;
	logic        valid;
	logic        ready;
	logic [63:0] color_word;
	logic [63:0] alpha_word;
	logic [10:0] block_col;
	logic [10:0] block_row;

	modport source (output valid, color_word, alpha_word, block_col, block_row, input ready);
	modport sink (input valid, color_word, alpha_word, block_col, block_row, output ready);
endinterface

interface bcd_tex_if;
	logic        valid;
	logic        ready;
	logic [12:0] pixel_x;
	logic [12:0] pixel_y;
	logic [31:0] argb;
	logic        last;

	modport source (output valid, pixel_x, pixel_y, argb, last, input ready);
	modport sink (input valid, pixel_x, pixel_y, argb, last, output ready);
endinterface

>>> design/bc1_bc3_block_decoder.sv
// bc1/bc3 block decoder: three-stage palette pipeline feeding a texel emitter
// path: stage 1, 2 and 3 registers, then the emitter, then the output register
// throughput: one texel per cycle while tex.ready does not stall the output register; a block holds
//   the emitter until it has issued its texels inside the image (up to 16), a fully clipped block issues none
// the texel emitter and its one-texel output register set the block rate
// arst_n clears all valid bits and restores format 0 (bc1) and a 256x256 image
module bc1_bc3_block_decoder
	import bcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bcd_blk_if.sink     blk,
	bcd_tex_if.source   tex,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [13:0] cfg_data
);

	function automatic logic [7:0] div3(input logic [9:0] n);
		logic [20:0] p;
		p = n * 11'd683;
		return p[18:11];
	endfunction

	function automatic logic [7:0] div5(input logic [10:0] n);
		logic [22:0] p;
		p = n * 12'd3277;
		return p[21:14];
	endfunction

	function automatic logic [7:0] div7(input logic [10:0] n);
		logic [22:0] p;
		p = n * 12'd2341;
		return p[21:14];
	endfunction

	// configuration registers
	logic        fmt_q;
	logic [13:0] width_q;
	logic [13:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= 1'b0;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FORMAT: fmt_q    <= cfg_data[0];
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline handshake
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic blk_v_s4;
	logic tex_v_q;
	logic issue;
	logic last_t;

	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign blk.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= blk.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// stage 1: endpoint expansion and clip mask
	logic [13:0] w_lim, h_lim;
	logic [12:0] ox, oy;
	logic [3:0]  col_ok, row_ok;
	logic [15:0] mask_in;
	logic [15:0] c0_in, c1_in;
	logic [7:0]  a0_in, a1_in;

	assign w_lim = (width_q > MAX_SIDE) ? MAX_SIDE : width_q;
	assign h_lim = (height_q > MAX_SIDE) ? MAX_SIDE : height_q;
	assign ox    = {blk.block_col, 2'b00};
	assign oy    = {blk.block_row, 2'b00};
	assign c0_in = blk.color_word[15:0];
	assign c1_in = blk.color_word[31:16];
	assign a0_in = blk.alpha_word[7:0];
	assign a1_in = blk.alpha_word[15:8];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			col_ok[i] = {1'b0, ox + 13'(i)} < w_lim;
			row_ok[i] = {1'b0, oy + 13'(i)} < h_lim;
		end
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				mask_in[r*4 + c] = row_ok[r] & col_ok[c];
			end
		end
	end

	logic        bc3_s1, punch_s1, ahi_s1;
	logic [23:0] e0_s1, e1_s1;
	logic [7:0]  a0_s1, a1_s1;
	logic [31:0] codes_s1;
	logic [47:0] aidx_s1;
	logic [12:0] ox_s1, oy_s1;
	logic [15:0] mask_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && blk.valid) begin
			bc3_s1   <= fmt_q;
			// three-color mode with transparent black only in bc1
			punch_s1 <= !fmt_q && !(c0_in > c1_in);
			ahi_s1   <= a0_in > a1_in;
			e0_s1    <= expand565(c0_in);
			e1_s1    <= expand565(c1_in);
			a0_s1    <= a0_in;
			a1_s1    <= a1_in;
			codes_s1 <= blk.color_word[63:32];
			aidx_s1  <= blk.alpha_word[63:16];
			ox_s1    <= ox;
			oy_s1    <= oy;
			mask_s1  <= mask_in;
		end
	end

	// stage 2: weighted sums for palette interpolation
	logic [9:0]  m21 [3];
	logic [9:0]  m12 [3];
	logic [8:0]  m11 [3];
	logic [10:0] s7 [6];
	logic [10:0] s5 [4];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m21[k] = {1'b0, e0_s1[k*8 +: 8], 1'b0} + {2'b00, e1_s1[k*8 +: 8]};
			m12[k] = {2'b00, e0_s1[k*8 +: 8]} + {1'b0, e1_s1[k*8 +: 8], 1'b0};
			m11[k] = {1'b0, e0_s1[k*8 +: 8]} + {1'b0, e1_s1[k*8 +: 8]};
		end
		for (int i = 1; i <= 6; i++) begin
			s7[i-1] = 11'((7 - i) * a0_s1 + i * a1_s1);
		end
		for (int i = 1; i <= 4; i++) begin
			s5[i-1] = 11'((5 - i) * a0_s1 + i * a1_s1);
		end
	end

	logic        bc3_s2, punch_s2, ahi_s2;
	logic [23:0] e0_s2, e1_s2;
	logic [7:0]  a0_s2, a1_s2;
	logic [31:0] codes_s2;
	logic [47:0] aidx_s2;
	logic [12:0] ox_s2, oy_s2;
	logic [15:0] mask_s2;
	logic [9:0]  m21_s2 [3];
	logic [9:0]  m12_s2 [3];
	logic [8:0]  m11_s2 [3];
	logic [10:0] s7_s2 [6];
	logic [10:0] s5_s2 [4];

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			bc3_s2   <= bc3_s1;
			punch_s2 <= punch_s1;
			ahi_s2   <= ahi_s1;
			e0_s2    <= e0_s1;
			e1_s2    <= e1_s1;
			a0_s2    <= a0_s1;
			a1_s2    <= a1_s1;
			codes_s2 <= codes_s1;
			aidx_s2  <= aidx_s1;
			ox_s2    <= ox_s1;
			oy_s2    <= oy_s1;
			mask_s2  <= mask_s1;
			m21_s2   <= m21;
			m12_s2   <= m12;
			m11_s2   <= m11;
			s7_s2    <= s7;
			s5_s2    <= s5;
		end
	end

	// stage 3: divide by constants, assemble color and alpha palettes
	logic [7:0]  c2 [3];
	logic [7:0]  c3 [3];
	logic [31:0] pal [4];
	logic [7:0]  alp [8];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			c2[k] = punch_s2 ? m11_s2[k][8:1] : div3(m21_s2[k]);
			c3[k] = div3(m12_s2[k]);
		end
		pal[0] = {ALPHA_OPAQUE, e0_s2};
		pal[1] = {ALPHA_OPAQUE, e1_s2};
		pal[2] = {ALPHA_OPAQUE, c2[2], c2[1], c2[0]};
		pal[3] = punch_s2 ? 32'h0 : {ALPHA_OPAQUE, c3[2], c3[1], c3[0]};
		alp[0] = a0_s2;
		alp[1] = a1_s2;
		for (int i = 0; i < 6; i++) begin
			if (ahi_s2) begin
				alp[i+2] = div7(s7_s2[i]);
			end else if (i < 4) begin
				alp[i+2] = div5(s5_s2[i]);
			end else if (i == 4) begin
				alp[i+2] = ALPHA_CLEAR;
			end else begin
				alp[i+2] = ALPHA_OPAQUE;
			end
		end
	end

	logic        bc3_s3;
	logic [31:0] pal_s3 [4];
	logic [7:0]  alp_s3 [8];
	logic [31:0] codes_s3;
	logic [47:0] aidx_s3;
	logic [12:0] ox_s3, oy_s3;
	logic [15:0] mask_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			bc3_s3   <= bc3_s2;
			pal_s3   <= pal;
			alp_s3   <= alp;
			codes_s3 <= codes_s2;
			aidx_s3  <= aidx_s2;
			ox_s3    <= ox_s2;
			oy_s3    <= oy_s2;
			mask_s3  <= mask_s2;
		end
	end

	// stage 4: texel emitter walks the remaining in-image texels, lowest first
	logic        bc3_s4;
	logic [31:0] pal_s4 [4];
	logic [7:0]  alp_s4 [8];
	logic [31:0] codes_s4;
	logic [47:0] aidx_s4;
	logic [12:0] ox_s4, oy_s4;
	logic [15:0] rem_s4;

	logic [15:0] rem_next, low;
	logic [3:0]  sel;
	logic [1:0]  ci;
	logic [2:0]  ai;
	logic [5:0]  abase;
	logic [31:0] argb_t;
	logic        load;

	always_comb begin
		rem_next = rem_s4 & (rem_s4 - 16'd1);
		low      = rem_s4 & ~rem_next;
		sel      = '0;
		for (int i = 0; i < 16; i++) begin
			if (low[i]) sel = sel | 4'(i);
		end
	end

	assign last_t = (rem_next == '0);
	assign ci     = codes_s4[{sel, 1'b0} +: 2];
	assign abase  = 6'({sel, 1'b0}) + {2'b00, sel};
	assign ai     = aidx_s4[abase +: 3];
	assign argb_t = bc3_s4 ? {alp_s4[ai], pal_s4[ci][23:0]} : pal_s4[ci];

	assign issue  = blk_v_s4 && (!tex_v_q || tex.ready);
	assign rdy_s4 = !blk_v_s4 || (issue && last_t);
	assign load   = v_s3 && rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_v_s4 <= 1'b0;
			rem_s4   <= '0;
		end else if (load) begin
			// a fully clipped block is dropped here
			blk_v_s4 <= |mask_s3;
			rem_s4   <= mask_s3;
		end else if (issue) begin
			blk_v_s4 <= !last_t;
			rem_s4   <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bc3_s4   <= bc3_s3;
			pal_s4   <= pal_s3;
			alp_s4   <= alp_s3;
			codes_s4 <= codes_s3;
			aidx_s4  <= aidx_s3;
			ox_s4    <= ox_s3;
			oy_s4    <= oy_s3;
		end
	end

	// output register
	logic [12:0] px_q, py_q;
	logic [31:0] argb_q;
	logic        last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_v_q <= 1'b0;
		end else if (issue) begin
			tex_v_q <= 1'b1;
		end else if (tex.ready) begin
			tex_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			px_q   <= ox_s4 + {11'd0, sel[1:0]};
			py_q   <= oy_s4 + {11'd0, sel[3:2]};
			argb_q <= argb_t;
			last_q <= last_t;
		end
	end

	assign tex.valid   = tex_v_q;
	assign tex.pixel_x = px_q;
	assign tex.pixel_y = py_q;
	assign tex.argb    = argb_q;
	assign tex.last    = last_q;

endmodule

>>> design/bcd_checker.sv
// port-level checks on the texel channel of the block decoder, bound to the top level
module bcd_checker
	import bcd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        tex_valid,
	input logic        tex_ready,
	input logic [12:0] pixel_x,
	input logic [12:0] pixel_y,
	input logic [31:0] argb,
	input logic        last,
	input logic        cfg_we,
	input logic [1:0]  cfg_idx,
	input logic [13:0] cfg_data
);

	// shadow copy of the configuration seen on the port
	logic        fmt_q;
	logic [13:0] w_q, h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b0;
			w_q   <= RST_WIDTH;
			h_q   <= RST_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FORMAT: fmt_q <= cfg_data[0];
				CFG_WIDTH:  w_q   <= cfg_data;
				CFG_HEIGHT: h_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		tex_valid && !tex_ready |=> tex_valid)
		else $error("texel dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		tex_valid && !tex_ready |=> $stable(pixel_x) && $stable(pixel_y)
			&& $stable(argb) && $stable(last))
		else $error("texel changed while stalled");

	a_inside_image: assert property (@(posedge clk) disable iff (!arst_n)
		tex_valid |-> ({1'b0, pixel_x} < w_q) && ({1'b0, pixel_y} < h_q))
		else $error("texel outside the image");

	a_bc1_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		tex_valid && !fmt_q |-> (argb[31:24] == ALPHA_OPAQUE) || (argb == 32'h0))
		else $error("bc1 texel with partial alpha");

endmodule

bind bc1_bc3_block_decoder bcd_checker u_bcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.tex_valid(tex.valid),
	.tex_ready(tex.ready),
	.pixel_x  (tex.pixel_x),
	.pixel_y  (tex.pixel_y),
	.argb     (tex.argb),
	.last     (tex.last),
	.cfg_we   (cfg_we),
	.cfg_idx  (cfg_idx),
	.cfg_data (cfg_data)
);
